// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation block
// Holds the operand width, the configuration register indexes, the
// transaction payload types and the controller-to-datapath signal groups.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of one half of an external 128-bit operand.
  localparam int HALF_W = 64;
  // Width of the full external operand.
  localparam int WIDE_W = 2 * HALF_W;
  // Working operand width; base, modulus and exponent are cut to this.
  localparam int KEY_BITS = 128;
  // Bit counter width for one pass over KEY_BITS bits.
  localparam int CNT_W = $clog2(KEY_BITS);
  // Index of the last bit in a pass.
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(KEY_BITS - 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_HI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_HI = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_LO = 2'd3;

  // Input transaction payload.
  typedef struct packed {
    logic [HALF_W-1:0] base_high;
    logic [HALF_W-1:0] base_low;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [HALF_W-1:0] power_high;
    logic [HALF_W-1:0] power_low;
    logic              modulus_zero;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture base and exponent, clear the work register
    logic step_en;      // one modular add step into the work register
    logic step_add;     // add the multiplicand instead of doubling
    logic add_sel_acc;  // multiplicand is the accumulator, else the base
    logic bit_in;       // shift the scan register top bit in as carry
    logic x_shift;      // shift the scan register left by one
    logic mul_start;    // load scan register from base, clear work register
    logic wr_base;      // base register takes the work register
    logic wr_acc;       // accumulator takes the work register
    logic acc_init;     // accumulator takes one mod modulus
    logic exp_shift;    // move to the next exponent bit
    logic out_load;     // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;  // configured modulus is zero
    logic x_msb;     // top bit of the scan register
    logic e_lsb;     // current exponent bit
  } dp_stat_t;

endpackage

// ===== rtl/modular_exponentiation_128.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_128: base^exponent mod modulus, 128-bit operands
// Right-to-left square-and-multiply built from a bit-serial modular adder.
// ----------------------------------------------------------------------------
// Usage:
//   Write modulus and exponent through the cfg_ channel (index 0 to 3:
//   modulus high, modulus low, exponent high, exponent low) while idle.
//   cfg_ready is always high. All four registers reset to zero.
//   An input transaction (in_valid high, in_stall low) carries the base.
//   in_stall is high from the cycle after acceptance until the result is
//   placed in the output register, so one transaction is worked at a time.
//   The base is first reduced bit by bit; then each exponent bit takes a
//   sequencing step, an optional multiply and a square. Each multiply or
//   square is a pass over the multiplier bits through the single
//   add-and-reduce unit: a doubling per bit and an add per set bit. A zero
//   modulus skips the computation and returns zero with modulus_zero set.
//   A result waits in the output register while out_stall is high; the next
//   transaction is accepted and worked meanwhile, and holds at its end
//   until the register is free. Reset drops out_valid and goes idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_128 import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Operand registers and arithmetic.
  mexp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // An accepted transaction keeps the input side busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after an accepted transaction");

  // A zero-modulus result carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.modulus_zero |->
      out_data.power_high == '0 && out_data.power_low == '0)
    else $error("zero modulus flagged with a nonzero result");

  // A new result only appears at the end of a transaction in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a transaction in progress");

endmodule

// ===== rtl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath: operand registers and the modular add unit
// Holds the configuration, the base, accumulator, work and scan registers,
// and one add-and-reduce unit that serves shift-subtract reduction and
// shift-add multiplication alike. Also holds the result register.
// ----------------------------------------------------------------------------
module mexp_datapath import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  input  in_t                  in_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output out_t                 out_data
);

  logic [HALF_W-1:0]   mod_hi_r, mod_lo_r, exp_hi_r, exp_lo_r;
  logic [WIDE_W-1:0]   mod_full, exp_full, base_full, acc_wide;
  logic [KEY_BITS-1:0] mod_k;
  logic [KEY_BITS-1:0] base_r, acc_r, work_r, x_r, e_r;
  logic [KEY_BITS-1:0] addend, work_nxt;
  logic [KEY_BITS:0]   sum;
  logic                zero_r;
  out_t                out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_hi_r <= '0;
      mod_lo_r <= '0;
      exp_hi_r <= '0;
      exp_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOD_HI: mod_hi_r <= cfg_data;
        REG_MOD_LO: mod_lo_r <= cfg_data;
        REG_EXP_HI: exp_hi_r <= cfg_data;
        REG_EXP_LO: exp_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operands cut to the working width.
  assign mod_full  = {mod_hi_r, mod_lo_r};
  assign exp_full  = {exp_hi_r, exp_lo_r};
  assign base_full = {in_data.base_high, in_data.base_low};
  assign mod_k     = mod_full[KEY_BITS-1:0];

  // Modular add: work + addend (+ carry-in bit), less the modulus once
  // when the sum reaches it. Both operands are below the modulus.
  always_comb begin
    addend = cmd.step_add ? (cmd.add_sel_acc ? acc_r : base_r) : work_r;
    sum = {1'b0, work_r} + {1'b0, addend}
        + {{KEY_BITS{1'b0}}, cmd.bit_in & x_r[KEY_BITS-1]};
    if (sum >= {1'b0, mod_k}) begin
      work_nxt = sum[KEY_BITS-1:0] - mod_k;
    end else begin
      work_nxt = sum[KEY_BITS-1:0];
    end
  end

  // Work and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= base_full[KEY_BITS-1:0];
      work_r <= '0;
      e_r    <= exp_full[KEY_BITS-1:0];
      zero_r <= (mod_k == '0);
    end else begin
      if (cmd.mul_start) begin
        x_r    <= base_r;
        work_r <= '0;
      end else begin
        if (cmd.x_shift) begin
          x_r <= {x_r[KEY_BITS-2:0], 1'b0};
        end
        if (cmd.step_en) begin
          work_r <= work_nxt;
        end
      end
      if (cmd.exp_shift) begin
        e_r <= {1'b0, e_r[KEY_BITS-1:1]};
      end
    end
  end

  // Base and accumulator registers.
  always_ff @(posedge clk) begin
    if (cmd.wr_base) begin
      base_r <= work_r;
    end
    if (cmd.acc_init) begin
      acc_r <= (mod_k == KEY_BITS'(1)) ? '0 : KEY_BITS'(1);
    end else if (cmd.wr_acc) begin
      acc_r <= work_r;
    end
  end

  // Result register; a zero modulus forces a zero result.
  always_comb begin
    acc_wide = '0;
    acc_wide[KEY_BITS-1:0] = acc_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.power_high   <= zero_r ? '0 : acc_wide[WIDE_W-1:HALF_W];
      out_r.power_low    <= zero_r ? '0 : acc_wide[HALF_W-1:0];
      out_r.modulus_zero <= zero_r;
    end
  end

  assign out_data      = out_r;
  assign stat.mod_zero = (mod_k == '0);
  assign stat.x_msb    = x_r[KEY_BITS-1];
  assign stat.e_lsb    = e_r[0];

endmodule

// ===== rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl: sequencer for square-and-multiply
// Steps through base reduction, then one optional multiply and one square
// per exponent bit, each as a bit-serial shift-add pass, and hands the
// result to the output register. A zero modulus skips straight to the result.
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REDB = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_EBIT = 3'd3;
  localparam logic [2:0] S_DBL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_MEND = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, ecnt_r, ecnt_nxt;
  logic             sqr_r, sqr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next-state and command logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ecnt_nxt  = ecnt_r;
    sqr_nxt   = sqr_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = stat.mod_zero ? S_DONE : S_REDB;
        end
      end
      S_REDB: begin
        // Shift-subtract reduction of the base, one bit per cycle.
        cmd.step_en = 1'b1;
        cmd.bit_in  = 1'b1;
        cmd.x_shift = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.wr_base  = 1'b1;
        cmd.acc_init = 1'b1;
        ecnt_nxt     = '0;
        state_nxt    = S_EBIT;
      end
      S_EBIT: begin
        // Multiply when the exponent bit is set, else go straight to square.
        cmd.mul_start = 1'b1;
        sqr_nxt       = ~stat.e_lsb;
        cnt_nxt       = '0;
        state_nxt     = S_DBL;
      end
      S_DBL: begin
        cmd.step_en = 1'b1;
        if (stat.x_msb) begin
          state_nxt = S_ADD;
        end else begin
          cmd.x_shift = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          state_nxt   = (cnt_r == LAST_BIT) ? S_MEND : S_DBL;
        end
      end
      S_ADD: begin
        cmd.step_en     = 1'b1;
        cmd.step_add    = 1'b1;
        cmd.add_sel_acc = ~sqr_r;
        cmd.x_shift     = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        state_nxt       = (cnt_r == LAST_BIT) ? S_MEND : S_DBL;
      end
      S_MEND: begin
        if (!sqr_r) begin
          // Multiply done; square the base next.
          cmd.wr_acc    = 1'b1;
          cmd.mul_start = 1'b1;
          sqr_nxt       = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DBL;
        end else begin
          cmd.wr_base   = 1'b1;
          cmd.exp_shift = 1'b1;
          ecnt_nxt      = ecnt_r + 1'b1;
          state_nxt     = (ecnt_r == LAST_BIT) ? S_DONE : S_EBIT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid holds until the receiver takes the transaction.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ecnt_r      <= '0;
      sqr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ecnt_r      <= ecnt_nxt;
      sqr_r       <= sqr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sim/mexp_power_check.sv =====
// ----------------------------------------------------------------------------
// mexp_power_check: result checker for the 128-bit modular exponentiation
// Follows the configuration writes and the input transactions, predicts
// base^exponent mod modulus for every accepted base, and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mexp_power_check import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  output int                   err_count,
  output int                   pending,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copies of the modulus and exponent registers.
  logic [WIDE_W-1:0] modulus_q;
  logic [WIDE_W-1:0] exponent_q;

  // Predicted results, oldest first.
  out_t power_q[$];
  out_t want;

  int mismatch_total = 0;
  int checked_total = 0;

  assign err_count = mismatch_total;
  assign checked = checked_total;

  // Right-to-left square-and-multiply on double-width vectors, so that
  // every product is reduced exactly by the native remainder operator.
  function automatic out_t expected_power(input logic [WIDE_W-1:0] modulus,
                                          input logic [WIDE_W-1:0] exponent,
                                          input logic [WIDE_W-1:0] base);
    logic [WIDE_W-1:0]   keep;
    logic [WIDE_W-1:0]   e;
    logic [2*WIDE_W-1:0] m;
    logic [2*WIDE_W-1:0] acc;
    logic [2*WIDE_W-1:0] run;
    out_t                res;
    keep = {WIDE_W{1'b1}} >> (WIDE_W - KEY_BITS);
    m = modulus & keep;
    e = exponent & keep;
    res = '0;
    // A zero modulus forces a zero result and raises the flag.
    if (m == '0) begin
      res.modulus_zero = 1'b1;
      return res;
    end
    run = (base & keep) % m;
    acc = (2*WIDE_W)'(1) % m;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (e[i]) begin
        acc = (acc * run) % m;
      end
      run = (run * run) % m;
    end
    res.power_high = acc[WIDE_W-1:HALF_W];
    res.power_low = acc[HALF_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [HALF_W-1:0] exp_val,
                             input logic [HALF_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, exp_val,
               act_val);
      mismatch_total++;
    end
  endtask

  // Compare results first, then track register writes and new bases.
  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_q <= '0;
      exponent_q <= '0;
      power_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (power_q.size() == 0) begin
          $display("%0t ns: result with none expected, actual %h", $time, out_data);
          mismatch_total++;
        end else begin
          want = power_q.pop_front();
          check_field("power_high", want.power_high, out_data.power_high);
          check_field("power_low", want.power_low, out_data.power_low);
          check_field("modulus_zero", HALF_W'(want.modulus_zero),
                      HALF_W'(out_data.modulus_zero));
          checked_total++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOD_HI: modulus_q[WIDE_W-1:HALF_W] <= cfg_data;
          REG_MOD_LO: modulus_q[HALF_W-1:0] <= cfg_data;
          REG_EXP_HI: exponent_q[WIDE_W-1:HALF_W] <= cfg_data;
          REG_EXP_LO: exponent_q[HALF_W-1:0] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        power_q.push_back(expected_power(modulus_q, exponent_q,
                                         {in_data.base_high, in_data.base_low}));
      end
      pending <= power_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the 128-bit modular exponentiation block
// Drives register settings and bursts of bases with random gaps, stalls the
// result side on its own pattern, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench import mexp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      RANDOM_ITEMS = 80;
  localparam int      HOLD_CYCLES = 200000;
  localparam int      TAIL_CYCLES = 100;
  localparam longint  CYCLE_LIMIT = 40000000;

  localparam logic [WIDE_W-1:0] ALL_ONES = '1;
  localparam logic [WIDE_W-1:0] TOP_BIT = {64'h8000000000000000, 64'h0};
  localparam logic [WIDE_W-1:0] SMALL_PRIME = {64'h0, 64'hFFFFFFFFFFFFFFC5};

  typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_MOST} stall_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HALF_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;

  logic   hold_req;
  int     err_count;
  int     pending;
  int     checked;
  int     sent_total = 0;
  int     config_total = 0;
  longint cycle_count = 0;
  in_t    bases[$];

  modular_exponentiation_128 DUT (.*);

  mexp_power_check power_check_i (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: stall modes change at random, with one long hold-off on
  // request so that the block fills up and stalls its input.
  initial begin
    stall_mode_e stall_mode;
    int unsigned mode_left;
    bit          hold_done;
    stall_mode = STALL_NONE;
    mode_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 4096);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [WIDE_W-1:0] random_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [WIDE_W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0, 1, 2: return random_wide();
      3, 4:    return {64'h0, $urandom, $urandom};
      5, 6:    return WIDE_W'($urandom_range(1, 65535));
      7:       return '0;
      8:       return WIDE_W'(1) << $urandom_range(0, KEY_BITS - 1);
      default: return ~WIDE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [WIDE_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return random_wide();
      4, 5:       return WIDE_W'($urandom_range(0, 65535));
      6:          return '0;
      7, 8:       return WIDE_W'(1) << $urandom_range(0, KEY_BITS - 1);
      default:    return ALL_ONES;
    endcase
  endfunction

  // Bases span full random values, values at and near the modulus, and
  // the extremes.
  function automatic in_t pick_base(input logic [WIDE_W-1:0] modulus);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return in_t'(random_wide());
      4:          return in_t'((modulus == '0) ? random_wide() : random_wide() % modulus);
      5:          return in_t'(WIDE_W'($urandom_range(0, 15)));
      6:          return in_t'(ALL_ONES);
      7:          return in_t'(WIDE_W'(0));
      8:          return in_t'(modulus);
      default:    return in_t'(modulus - 1'b1);
    endcase
  endfunction

  // Register writes keep valid high across the four transactions.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input logic [WIDE_W-1:0] modulus,
                             input logic [WIDE_W-1:0] exponent);
    write_reg(REG_MOD_HI, modulus[WIDE_W-1:HALF_W]);
    write_reg(REG_MOD_LO, modulus[HALF_W-1:0]);
    write_reg(REG_EXP_HI, exponent[WIDE_W-1:HALF_W]);
    write_reg(REG_EXP_LO, exponent[HALF_W-1:0]);
    cfg_valid <= 1'b0;
    config_total++;
  endtask

  task automatic offer_base(input in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sent_total++;
  endtask

  // Sends the queued bases in bursts of random length with random gaps.
  task automatic send_bases();
    int unsigned burst;
    burst = $urandom_range(1, 4);
    foreach (bases[i]) begin
      offer_base(bases[i]);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 4);
        in_valid <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1000, 40000)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
    end
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [WIDE_W-1:0] modulus,
                           input logic [WIDE_W-1:0] exponent, input bit hold);
    settle();
    load_config(modulus, exponent);
    if (hold) begin
      hold_req <= 1'b1;
    end
    send_bases();
  endtask

  // Main stimulus sequence.
  initial begin
    logic [WIDE_W-1:0] modulus;
    logic [WIDE_W-1:0] exponent;
    int unsigned       count;
    int                random_sent;
    bit                hold_used;
    random_sent = 0;
    hold_used = 1'b0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MOD_HI;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    hold_req <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at their reset value: zero modulus.
    bases = '{in_t'(ALL_ONES), in_t'(WIDE_W'(0))};
    send_bases();

    // Zero exponent with the largest modulus gives one.
    bases = '{in_t'(WIDE_W'(0)), in_t'(ALL_ONES), in_t'({64'h1, 64'h0})};
    run_phase(ALL_ONES, '0, 1'b0);

    // A modulus of one gives zero even for a zero exponent.
    bases = '{in_t'(WIDE_W'(1)), in_t'(ALL_ONES)};
    run_phase(WIDE_W'(1), '0, 1'b0);

    // All-ones exponent and modulus: the slowest case.
    bases = '{in_t'(WIDE_W'(1)), in_t'(ALL_ONES - 1'b1), in_t'(ALL_ONES)};
    run_phase(ALL_ONES, ALL_ONES, 1'b0);

    // Bases well above a 64-bit modulus must be reduced first.
    bases = '{in_t'(ALL_ONES), in_t'({64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555}),
              in_t'({64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA}), in_t'(SMALL_PRIME)};
    run_phase(SMALL_PRIME, WIDE_W'(65537), 1'b0);

    // Only the top bit set in modulus and exponent.
    bases = '{in_t'(WIDE_W'(3)), in_t'(TOP_BIT)};
    run_phase(TOP_BIT, TOP_BIT, 1'b0);

    // Zero modulus written explicitly.
    bases = '{in_t'(random_wide()), in_t'(random_wide())};
    run_phase('0, random_wide(), 1'b0);

    // Random settings, each with a short run of random bases. The first
    // one also holds off the result side for a long stretch.
    while (random_sent < RANDOM_ITEMS) begin
      modulus = pick_modulus();
      exponent = pick_exponent();
      count = hold_used ? $urandom_range(3, 8) : 6;
      bases.delete();
      repeat (count) bases.push_back(pick_base(modulus));
      run_phase(modulus, exponent, !hold_used);
      hold_used = 1'b1;
      random_sent += count;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d results from %0d bases over %0d register settings.",
             checked, sent_total, config_total);
    $display("Settings included zero, unit and full-width moduli, zero and all-ones exponents.");
    if (err_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mexp_pkg.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_128.sv
sim/mexp_power_check.sv
sim/testbench.sv
